// ===== src/gpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_pkg: shared definitions for the GF(2) polynomial inverse block
// Holds the default field degree, the default modulus and the controller states.
// ----------------------------------------------------------------------------
package gpi_pkg;

  localparam int unsigned FieldDegreeDefault = 8;
  localparam int unsigned ModulusResetDefault = 283;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN
  } state_e;

endpackage

// ===== src/gf2_poly_inverse_euclid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_poly_inverse_euclid: GF(2) polynomial inverse by extended Euclid
// Returns the gcd and Bezout coefficient of an element against the modulus.
// ----------------------------------------------------------------------------
// One item is worked on at a time. At acceptance the row of bit cells is
// loaded with the modulus and the element (a zero element loads zero remainders,
// so its result is zero). Each following cycle runs one step while r is nonzero:
// when old_r has a lower degree than r the pairs are swapped, otherwise r and s,
// shifted to align with the leading term of old_r, are cancelled into old_r and
// old_s. Every cancelling step lowers the sum of the two remainder degrees, so
// there are at most 2*FIELD_DEGREE of them and at most one more swap than that,
// giving at most 4*FIELD_DEGREE+1 steps. The input stays stalled from the
// loading of an item until its result register is written, so the serial step
// loop sets how long an item holds it. The result waits in its own register, so
// the next item can start while it is held; a new result is only written once
// that register is free or being emptied. The modulus is written only while the
// block is idle.
module gf2_poly_inverse_euclid #(
  parameter int unsigned FIELD_DEGREE = gpi_pkg::FieldDegreeDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [FIELD_DEGREE:0]   modulus_poly_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [FIELD_DEGREE-1:0] element_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [FIELD_DEGREE-1:0] gcd_poly_o,
  output logic [FIELD_DEGREE-1:0] inverse_poly_o
);

  localparam int unsigned W  = FIELD_DEGREE + 1;
  localparam int unsigned DW = $clog2(W + 1);

  gpi_pkg::state_e state_q, state_d;
  logic [FIELD_DEGREE:0] mod_q;

  logic [W-1:0] old_r, r, old_s, s;
  logic [W-1:0] r_sh, s_sh;
  logic [W-1:0] elem_ext;
  logic [DW-1:0] deg_old, deg_r;
  logic [DW-1:0] shift;
  logic load, step, swap, done_now, elem_nz;
  logic out_valid_q;
  logic [FIELD_DEGREE-1:0] gcd_q, inv_q;

  // Degree of a polynomial plus one, zero for the zero polynomial.
  function automatic logic [DW-1:0] deg1(input logic [W-1:0] p);
    logic [DW-1:0] d;
    d = '0;
    for (int i = 0; i < W; i++) begin
      if (p[i]) d = DW'(i + 1);
    end
    return d;
  endfunction

  assign deg_old = deg1(old_r);
  assign deg_r   = deg1(r);
  assign shift   = deg_old - deg_r;
  assign r_sh    = r << shift;
  assign s_sh    = s << shift;

  assign elem_ext = {1'b0, element_i};
  assign elem_nz  = (element_i != '0);

  // When old_r has lower degree than r, the quotient for this round is done
  // and the pairs are swapped; otherwise the aligned r is cancelled.
  assign load = (state_q == gpi_pkg::ST_IDLE) && in_valid_i;
  assign step = (state_q == gpi_pkg::ST_RUN) && (r != '0);
  assign swap = deg_old < deg_r;
  assign done_now = (state_q == gpi_pkg::ST_RUN) && (r == '0) &&
                    (!out_valid_q || !out_stall_i);

  for (genvar g = 0; g < W; g++) begin : g_cell
    gpi_cell u_cell (
      .clk_i      (clk_i),
      .load_i     (load),
      .step_i     (step),
      .swap_i     (swap),
      .ld_old_r_i (mod_q[g] & elem_nz),
      .ld_r_i     (elem_ext[g]),
      .ld_old_s_i (1'b0),
      .ld_s_i     (g == 0),
      .r_in_i     (r_sh[g]),
      .s_in_i     (s_sh[g]),
      .old_r_o    (old_r[g]),
      .r_o        (r[g]),
      .old_s_o    (old_s[g]),
      .s_o        (s[g])
    );
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gpi_pkg::ST_IDLE: if (in_valid_i) state_d = gpi_pkg::ST_RUN;
      gpi_pkg::ST_RUN:  if (done_now) state_d = gpi_pkg::ST_IDLE;
      default:          state_d = gpi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gpi_pkg::ST_IDLE;
      mod_q       <= (FIELD_DEGREE + 1)'(gpi_pkg::ModulusResetDefault);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) mod_q <= modulus_poly_i;
      if (done_now) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_now) begin
      gcd_q <= old_r[FIELD_DEGREE-1:0];
      inv_q <= old_s[FIELD_DEGREE-1:0];
    end
  end

  always_comb begin
    in_stall_o  = (state_q != gpi_pkg::ST_IDLE);
    out_valid_o = out_valid_q;
    cfg_ready_o = (state_q == gpi_pkg::ST_IDLE);
  end
  assign gcd_poly_o     = gcd_q;
  assign inverse_poly_o = inv_q;

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gpi_pkg::ST_RUN) |-> in_stall_o) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(gcd_poly_o) && $stable(inverse_poly_o)))
    else $error("result dropped");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_now |=> out_valid_o) else $error("finished result not presented");
  a_accept_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == gpi_pkg::ST_RUN))
    else $error("accepted item not started");

endmodule

// ===== src/gpi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpi_cell: one bit slice of the remainder and coefficient registers
// Holds one bit of each of the four polynomials used by the Euclid step.
// ----------------------------------------------------------------------------
module gpi_cell (
  input  logic clk_i,
  input  logic load_i,
  input  logic step_i,
  input  logic swap_i,
  input  logic ld_old_r_i,
  input  logic ld_r_i,
  input  logic ld_old_s_i,
  input  logic ld_s_i,
  input  logic r_in_i,
  input  logic s_in_i,
  output logic old_r_o,
  output logic r_o,
  output logic old_s_o,
  output logic s_o
);

  logic old_r_q, r_q, old_s_q, s_q;
  logic old_r_d, r_d, old_s_d, s_d;

  // r_in_i and s_in_i are r and s already shifted into this bit position.
  // A step either exchanges the pairs or cancels with the aligned r and s.
  always_comb begin
    old_r_d = old_r_q;
    r_d     = r_q;
    old_s_d = old_s_q;
    s_d     = s_q;
    if (load_i) begin
      old_r_d = ld_old_r_i;
      r_d     = ld_r_i;
      old_s_d = ld_old_s_i;
      s_d     = ld_s_i;
    end else if (step_i) begin
      if (swap_i) begin
        old_r_d = r_q;
        r_d     = old_r_q;
        old_s_d = s_q;
        s_d     = old_s_q;
      end else begin
        old_r_d = old_r_q ^ r_in_i;
        old_s_d = old_s_q ^ s_in_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    old_r_q <= old_r_d;
    r_q     <= r_d;
    old_s_q <= old_s_d;
    s_q     <= s_d;
  end

  assign old_r_o = old_r_q;
  assign r_o     = r_q;
  assign old_s_o = old_s_q;
  assign s_o     = s_q;

endmodule
